// File: rtl/mtt_pkg.sv
// Package for the matrix times transpose core: field widths, register codes,
// sequencer states and the pipeline tag shared by the control and datapath.
// Depends on nothing.
`default_nettype none

package mtt_pkg;

   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 32;
   localparam int DOT_W     = 48;
   localparam int B_ROW_W   = 4;
   localparam int COL_IDX_W = 8;
   localparam int RCOL_W    = 4;
   localparam int COLS_W    = 9;
   localparam int BROWS_W   = 5;
   localparam int AROWS_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS_IN_USE = 2'd2;

   localparam logic ACTION_LOAD_B   = 1'b0;
   localparam logic ACTION_STREAM_A = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic last_j;
      logic row_end;
      logic last_mat;
   } stage_tag_type;

endpackage

`default_nettype wire

// File: rtl/mtt_bstore.sv
// Store of the B matrix: one write port, one read port with registered data.
// Depends on mtt_pkg for the element width.
`default_nettype none

module mtt_bstore #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [AW-1:0]               waddr,
   input  wire logic [mtt_pkg::VALUE_W-1:0] wdata,
   input  wire logic                        re,
   input  wire logic [AW-1:0]               raddr,
   output logic      [mtt_pkg::VALUE_W-1:0] rdata
);
   import mtt_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/mtt_mac.sv
// Multiply-accumulate datapath: product register, accumulator file per B row
// and the registered result port. Depends on mtt_pkg.
`default_nettype none

module mtt_mac #(
   parameter int MAX_B_ROWS = 16,
   parameter int JW         = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               prod_en,
   input  wire logic signed [mtt_pkg::VALUE_W-1:0] value,
   input  wire logic        [mtt_pkg::VALUE_W-1:0] rdata,
   input  wire mtt_pkg::stage_tag_type             s2_tag,
   input  wire logic        [JW-1:0]               s2_j,
   output logic                                    rsp_valid,
   output logic signed      [mtt_pkg::DOT_W-1:0]   rsp_dot_value,
   output logic             [mtt_pkg::RCOL_W-1:0]  rsp_result_col,
   output logic                                    rsp_last_of_row,
   output logic                                    rsp_last_of_matrix
);
   import mtt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DOT_W-1:0]  acc_ff [MAX_B_ROWS];
   logic signed [DOT_W-1:0]  sum_in;
   logic                     rsp_valid_ff;
   logic signed [DOT_W-1:0]  rsp_dot_ff;
   logic [RCOL_W-1:0]        rsp_col_ff;
   logic                     rsp_last_row_ff;
   logic                     rsp_last_mat_ff;

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= value * $signed(rdata);
      end
   end

   assign sum_in = acc_ff[s2_j] + DOT_W'(prod_ff);

   // Every accumulator clears at the end of a row, also those of rows no longer in use.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_B_ROWS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (s2_tag.valid) begin
         if (s2_tag.row_end && s2_tag.last_j) begin
            for (int i = 0; i < MAX_B_ROWS; i++) begin
               acc_ff[i] <= '0;
            end
         end else begin
            acc_ff[s2_j] <= s2_tag.row_end ? '0 : sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_tag.valid && s2_tag.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_tag.valid && s2_tag.row_end) begin
         rsp_dot_ff      <= sum_in;
         rsp_col_ff      <= RCOL_W'(s2_j);
         rsp_last_row_ff <= s2_tag.last_j;
         rsp_last_mat_ff <= s2_tag.last_mat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dot_value      = rsp_dot_ff;
   assign rsp_result_col     = rsp_col_ff;
   assign rsp_last_of_row    = rsp_last_row_ff;
   assign rsp_last_of_matrix = rsp_last_mat_ff;

endmodule

`default_nettype wire

// File: rtl/mtt_ctrl.sv
// Sequencer: configuration registers, column and row counters, store write
// decode and the sweep over B rows with its pipeline tags. Depends on mtt_pkg.
`default_nettype none

module mtt_ctrl #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_B_ROWS = 16,
   parameter int AW         = 12,
   parameter int JW         = 4,
   parameter int COL_W      = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_action,
   input  wire logic        [mtt_pkg::B_ROW_W-1:0]  req_b_row_index,
   input  wire logic        [mtt_pkg::COL_IDX_W-1:0] req_col_index,
   input  wire logic signed [mtt_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [mtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [mtt_pkg::CSR_DAT_W-1:0] csr_wdata,
   output logic                                     mem_we,
   output logic             [AW-1:0]                mem_waddr,
   output logic             [mtt_pkg::VALUE_W-1:0]  mem_wdata,
   output logic                                     mem_re,
   output logic             [AW-1:0]                mem_raddr,
   output logic signed      [mtt_pkg::VALUE_W-1:0]  value,
   output logic                                     prod_en,
   output mtt_pkg::stage_tag_type                   s2_tag,
   output logic             [JW-1:0]                s2_j
);
   import mtt_pkg::*;

   localparam int ColCmpW = ($clog2(MAX_COLS + 1) > COLS_W ?
                             $clog2(MAX_COLS + 1) : COLS_W) + 1;
   localparam int RowCmpW = ($clog2(MAX_B_ROWS + 1) > BROWS_W ?
                             $clog2(MAX_B_ROWS + 1) : BROWS_W) + 1;

   state_type state_ff, state_in;

   logic [COLS_W-1:0]      cols_ff;
   logic [BROWS_W-1:0]     brows_ff;
   logic [AROWS_W-1:0]     arows_ff;
   logic [COL_W-1:0]       column_count_ff, column_count_in;
   logic [AROWS_W-1:0]     a_row_count_ff, a_row_count_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic [COL_W-1:0]       col_ff;
   logic                   row_end_ff, row_end_in;
   logic                   last_mat_ff, last_mat_in;
   logic [JW-1:0]          nb_last_ff, nb_last_in;
   logic [JW-1:0]          j_ff, j_in;
   stage_tag_type          s1_ff, s1_in;
   logic [JW-1:0]          s1_j_ff;
   stage_tag_type          s2_ff;
   logic [JW-1:0]          s2_j_ff;

   logic                   accept;
   logic                   accept_a;
   logic                   sweeping;
   logic [ColCmpW-1:0]     c_plus;
   logic [ColCmpW-1:0]     eff_cols;
   logic [RowCmpW-1:0]     eff_brows;
   logic [AROWS_W:0]       a_plus;
   logic [AROWS_W:0]       eff_arows;
   logic                   load_ok;

   assign accept   = start && !busy;
   assign accept_a = accept && (req_action == ACTION_STREAM_A);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_a) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (j_ff == nb_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy     = 1'b1;
      sweeping = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_SWEEP: sweeping = 1'b1;
         ST_DRAIN: busy = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_W'(256);
         brows_ff <= BROWS_W'(16);
         arows_ff <= AROWS_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COLS_IN_USE:   cols_ff  <= csr_wdata[COLS_W-1:0];
            CSR_B_ROWS_IN_USE: brows_ff <= csr_wdata[BROWS_W-1:0];
            CSR_A_ROWS_IN_USE: arows_ff <= csr_wdata[AROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      c_plus = ColCmpW'(column_count_ff) + ColCmpW'(1);
      if (cols_ff == '0) begin
         eff_cols = ColCmpW'(1);
      end else if (ColCmpW'(cols_ff) > ColCmpW'(MAX_COLS)) begin
         eff_cols = ColCmpW'(MAX_COLS);
      end else begin
         eff_cols = ColCmpW'(cols_ff);
      end
      if (brows_ff == '0) begin
         eff_brows = RowCmpW'(1);
      end else if (RowCmpW'(brows_ff) > RowCmpW'(MAX_B_ROWS)) begin
         eff_brows = RowCmpW'(MAX_B_ROWS);
      end else begin
         eff_brows = RowCmpW'(brows_ff);
      end
      a_plus    = (AROWS_W + 1)'(a_row_count_ff) + (AROWS_W + 1)'(1);
      eff_arows = (arows_ff == '0) ? (AROWS_W + 1)'(1) : (AROWS_W + 1)'(arows_ff);

      row_end_in  = (c_plus >= eff_cols);
      last_mat_in = row_end_in && (a_plus >= eff_arows);
      nb_last_in  = JW'(eff_brows - RowCmpW'(1));

      column_count_in = column_count_ff;
      a_row_count_in  = a_row_count_ff;
      if (accept_a) begin
         column_count_in = row_end_in ? '0 : COL_W'(c_plus);
         if (row_end_in) begin
            a_row_count_in = last_mat_in ? '0 : AROWS_W'(a_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         a_row_count_ff  <= '0;
      end else begin
         column_count_ff <= column_count_in;
         a_row_count_ff  <= a_row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_a) begin
         value_ff    <= req_value;
         col_ff      <= column_count_ff;
         row_end_ff  <= row_end_in;
         last_mat_ff <= last_mat_in;
         nb_last_ff  <= nb_last_in;
      end
   end

   always_comb begin
      j_in = j_ff;
      if (accept_a) begin
         j_in = '0;
      end else if (sweeping) begin
         j_in = j_ff + JW'(1);
      end
      s1_in.valid    = sweeping;
      s1_in.last_j   = (j_ff == nb_last_ff);
      s1_in.row_end  = row_end_ff;
      s1_in.last_mat = last_mat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff  <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         j_ff  <= j_in;
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_j_ff <= j_ff;
      s2_j_ff <= s1_j_ff;
   end

   assign load_ok = (ColCmpW'(req_col_index) < ColCmpW'(MAX_COLS)) &&
                    (RowCmpW'(req_b_row_index) < RowCmpW'(MAX_B_ROWS));

   assign mem_we    = accept && (req_action == ACTION_LOAD_B) && load_ok;
   assign mem_waddr = AW'(req_b_row_index) * AW'(MAX_COLS) + AW'(req_col_index);
   assign mem_wdata = req_value;
   assign mem_re    = sweeping;
   assign mem_raddr = AW'(j_ff) * AW'(MAX_COLS) + AW'(col_ff);

   assign value   = value_ff;
   assign prod_en = s1_ff.valid;
   assign s2_tag  = s2_ff;
   assign s2_j    = s2_j_ff;

endmodule

`default_nettype wire

// File: rtl/matrix_times_transpose_core.sv
// Top level of the matrix times transpose core, R = A * B^T in Q8.8 / Q32.16.
// Instantiates mtt_ctrl, mtt_bstore and mtt_mac; depends on mtt_pkg.
//
//   Port group  Direction  Handshake              Carries
//   req_        in         start high, busy low   action, B row, column, value
//   rsp_        out        rsp_valid strobe       dot value, column, last flags
//   csr_        in         csr_valid and ready    register index, write data
//
// A B load leaves busy low, so the next item may follow.
// An A element keeps busy high while its nb B row elements are read, nb being
// the B rows in use, since the single store read port gives one per cycle.
// Row-end results leave one per cycle via store, product and result registers.
// Reset is synchronous and clears the counters and accumulators; the B store
// holds no reset value. Results cannot be stalled by the receiver.
`default_nettype none

module matrix_times_transpose_core #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_B_ROWS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_action,
   input  wire logic        [mtt_pkg::B_ROW_W-1:0]  req_b_row_index,
   input  wire logic        [mtt_pkg::COL_IDX_W-1:0] req_col_index,
   input  wire logic signed [mtt_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_valid,
   output logic signed      [mtt_pkg::DOT_W-1:0]    rsp_dot_value,
   output logic             [mtt_pkg::RCOL_W-1:0]   rsp_result_col,
   output logic                                     rsp_last_of_row,
   output logic                                     rsp_last_of_matrix,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [mtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [mtt_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import mtt_pkg::*;

   localparam int Depth = MAX_B_ROWS * MAX_COLS;
   localparam int AW    = Depth > 1 ? $clog2(Depth) : 1;
   localparam int JW    = MAX_B_ROWS > 1 ? $clog2(MAX_B_ROWS) : 1;
   localparam int ColW  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;
   logic                      mem_re;
   logic [AW-1:0]             mem_raddr;
   logic [VALUE_W-1:0]        mem_rdata;
   logic signed [VALUE_W-1:0] value;
   logic                      prod_en;
   stage_tag_type             s2_tag;
   logic [JW-1:0]             s2_j;

   mtt_ctrl #(
      .MAX_COLS   (MAX_COLS),
      .MAX_B_ROWS (MAX_B_ROWS),
      .AW         (AW),
      .JW         (JW),
      .COL_W      (ColW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_b_row_index (req_b_row_index),
      .req_col_index   (req_col_index),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .value           (value),
      .prod_en         (prod_en),
      .s2_tag          (s2_tag),
      .s2_j            (s2_j)
   );

   mtt_bstore #(
      .DEPTH (Depth),
      .AW    (AW)
   ) u_bstore (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mtt_mac #(
      .MAX_B_ROWS (MAX_B_ROWS),
      .JW         (JW)
   ) u_mac (
      .clock              (clock),
      .reset              (reset),
      .prod_en            (prod_en),
      .value              (value),
      .rdata              (mem_rdata),
      .s2_tag             (s2_tag),
      .s2_j               (s2_j),
      .rsp_valid          (rsp_valid),
      .rsp_dot_value      (rsp_dot_value),
      .rsp_result_col     (rsp_result_col),
      .rsp_last_of_row    (rsp_last_of_row),
      .rsp_last_of_matrix (rsp_last_of_matrix)
   );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for matrix_times_transpose_core, R = A * B^T.
// Depends on mtt_pkg and the core; drives items, registers and checks every dot product
// against a predictor of the store, accumulators and row counters kept here.
`timescale 1ns / 100ps

module tb_top;
   import mtt_pkg::*;

   localparam int MAX_COLS      = 256;
   localparam int MAX_B_ROWS    = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int ITEM_TARGET   = 430;
   localparam int DIRECTED_ROWS = 24;

   typedef struct {
      logic signed [DOT_W-1:0] dot;
      logic [RCOL_W-1:0]       col;
      logic                    row_end;
      logic                    mat_end;
   } dot_result_type;

   typedef struct {
      logic                    is_csr;
      logic [CSR_IDX_W-1:0]    csr_idx;
      logic                    action;
      logic [B_ROW_W-1:0]      brow;
      logic [COL_IDX_W-1:0]    col;
      logic [VALUE_W-1:0]      value;
      logic                    has_dot;
      logic signed [DOT_W-1:0] dot;
   } step_row_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = ACTION_LOAD_B;
   logic [B_ROW_W-1:0] req_b_row_index = '0;
   logic [COL_IDX_W-1:0] req_col_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic signed [DOT_W-1:0] rsp_dot_value;
   logic [RCOL_W-1:0] rsp_result_col;
   logic rsp_last_of_row;
   logic rsp_last_of_matrix;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLS_IN_USE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   logic signed [VALUE_W-1:0] b_copy [MAX_B_ROWS][MAX_COLS];
   bit b_loaded [MAX_B_ROWS][MAX_COLS];
   logic signed [DOT_W-1:0] row_sums [MAX_B_ROWS];
   int col_count = 0;
   int a_row_count = 0;
   logic [COLS_W-1:0] reg_cols = 9'd256;
   logic [BROWS_W-1:0] reg_b_rows = 5'd16;
   logic [AROWS_W-1:0] reg_a_rows = 16'd1;

   dot_result_type expected_dots [$];
   step_row_type directed_steps [DIRECTED_ROWS];
   int errors = 0;
   int items_accepted = 0;
   int dots_checked = 0;
   int phases = 0;
   int cycles = 0;
   int sender_idle_pct = 17;

   matrix_times_transpose_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_b_row_index(req_b_row_index),
      .req_col_index(req_col_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_dot_value(rsp_dot_value),
      .rsp_result_col(rsp_result_col), .rsp_last_of_row(rsp_last_of_row),
      .rsp_last_of_matrix(rsp_last_of_matrix),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, expected_dots.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic int used_cols();
      if (reg_cols == 0) return 1;
      return (reg_cols > MAX_COLS) ? MAX_COLS : int'(reg_cols);
   endfunction

   function automatic int used_b_rows();
      if (reg_b_rows == 0) return 1;
      return (reg_b_rows > MAX_B_ROWS) ? MAX_B_ROWS : int'(reg_b_rows);
   endfunction

   function automatic int used_a_rows();
      return (reg_a_rows == 0) ? 1 : int'(reg_a_rows);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return -16'sh0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic predict_dot_products(input logic act, input logic [B_ROW_W-1:0] brow,
                                       input logic [COL_IDX_W-1:0] col,
                                       input logic signed [VALUE_W-1:0] val);
      int nb;
      int c;
      int j;
      logic signed [PROD_W-1:0] prod;
      logic last_mat;
      dot_result_type r;
      if (act == ACTION_LOAD_B) begin
         b_copy[brow][col] = val;
         b_loaded[brow][col] = 1'b1;
      end else begin
         nb = used_b_rows();
         c = col_count;
         for (j = 0; j < nb; j++) begin
            prod = val * b_copy[j][c];
            row_sums[j] = row_sums[j] + prod;
         end
         if (c + 1 < used_cols()) begin
            col_count = c + 1;
         end else begin
            last_mat = (a_row_count + 1 >= used_a_rows());
            for (j = 0; j < nb; j++) begin
               r.dot = row_sums[j];
               r.col = j[RCOL_W-1:0];
               r.row_end = (j == nb - 1);
               r.mat_end = last_mat;
               expected_dots.push_back(r);
            end
            for (j = 0; j < MAX_B_ROWS; j++) row_sums[j] = '0;
            col_count = 0;
            a_row_count = last_mat ? 0 : ((a_row_count + 1) & 16'hFFFF);
         end
      end
   endtask

   task automatic send_item(input logic act, input logic [B_ROW_W-1:0] brow,
                            input logic [COL_IDX_W-1:0] col,
                            input logic signed [VALUE_W-1:0] val);
      csr_valid <= 1'b0;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_b_row_index <= brow;
      req_col_index <= col;
      req_value <= val;
      do @(posedge clock); while (busy);
      predict_dot_products(act, brow, col, val);
      items_accepted++;
      if (items_accepted < 160) sender_idle_pct = 17;
      else if (items_accepted < 300) sender_idle_pct = 77;
      else sender_idle_pct = 0;
   endtask

   // Loads any store entry the next A element would read that was never written.
   task automatic fill_missing();
      int j;
      for (j = 0; j < used_b_rows(); j++)
         if (!b_loaded[j][col_count])
            send_item(ACTION_LOAD_B, j[B_ROW_W-1:0], col_count[COL_IDX_W-1:0], pick_value());
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (expected_dots.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COLS_IN_USE:   reg_cols = data[COLS_W-1:0];
         CSR_B_ROWS_IN_USE: reg_b_rows = data[BROWS_W-1:0];
         CSR_A_ROWS_IN_USE: reg_a_rows = data[AROWS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_random_reg();
      case ($urandom_range(0, 2))
         0: write_csr(CSR_COLS_IN_USE,
                      16'({$urandom_range(0, 127), 9'($urandom_range(0, 8))}));
         1: write_csr(CSR_B_ROWS_IN_USE,
                      16'({$urandom_range(0, 2047), 5'($urandom_range(0, 31))}));
         default: write_csr(CSR_A_ROWS_IN_USE, 16'($urandom_range(0, 4)));
      endcase
   endtask

   always @(posedge clock) begin
      dot_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_dots.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: dot %0d col %0d row_end %0b mat_end %0b",
                     $time, rsp_dot_value, rsp_result_col, rsp_last_of_row,
                     rsp_last_of_matrix);
         end else begin
            want = expected_dots.pop_front();
            dots_checked++;
            if (rsp_dot_value !== want.dot || rsp_result_col !== want.col ||
                rsp_last_of_row !== want.row_end || rsp_last_of_matrix !== want.mat_end) begin
               errors++;
               $display("%0t: expected dot %0d col %0d row_end %0b mat_end %0b,",
                        $time, want.dot, want.col, want.row_end, want.mat_end);
               $display("   got dot %0d col %0d row_end %0b mat_end %0b",
                        rsp_dot_value, rsp_result_col, rsp_last_of_row, rsp_last_of_matrix);
            end
         end
      end
   end

   initial begin
      int i;
      int j;
      int c;
      int n;
      int r;
      dot_result_type typed;
      for (i = 0; i < MAX_B_ROWS; i++) row_sums[i] = '0;
      directed_steps = '{
         '{1, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 0, 16'd1, 0, 0},
         '{1, CSR_B_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd1, 0, 0},
         '{1, CSR_A_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd1, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 0, 16'h7FFF, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h7FFF, 1, 48'sd1073676289},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h8000, 1, -48'sd1073709056},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 0, 16'h8000, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h8000, 1, 48'sd1073741824},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h0001, 1, -48'sd32768},
         '{1, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 0, 16'd0, 0, 0},
         '{1, CSR_B_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd0, 0, 0},
         '{1, CSR_A_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd0, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'hFFFF, 1, 48'sd32768},
         '{1, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 0, 16'd2, 0, 0},
         '{1, CSR_B_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd2, 0, 0},
         '{1, CSR_A_ROWS_IN_USE, ACTION_LOAD_B,   0, 0, 16'd2, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,   1, 0, 16'h7FFF, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,   0, 1, 16'h1234, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,   1, 1, 16'h8000, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h7FFF, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h8000, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'h0100, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_STREAM_A, 0, 0, 16'hFFFF, 0, 0},
         '{0, CSR_COLS_IN_USE,   ACTION_LOAD_B,  15, 255, 16'h5A5A, 0, 0}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_steps[i].is_csr) begin
            wait_quiet();
            write_csr(directed_steps[i].csr_idx, directed_steps[i].value);
         end else begin
            if (directed_steps[i].action == ACTION_STREAM_A) fill_missing();
            send_item(directed_steps[i].action, directed_steps[i].brow,
                      directed_steps[i].col, directed_steps[i].value);
            if (directed_steps[i].has_dot) begin
               void'(expected_dots.pop_back());
               typed.dot = directed_steps[i].dot;
               typed.col = '0;
               typed.row_end = 1'b1;
               typed.mat_end = 1'b1;
               expected_dots.push_back(typed);
            end
         end
      end

      while (items_accepted < ITEM_TARGET) begin
         wait_quiet();
         if (phases == 0) begin
            write_csr(CSR_COLS_IN_USE, 16'($urandom_range(2, 6)));
            write_csr(CSR_B_ROWS_IN_USE, 16'd31);
            write_csr(CSR_A_ROWS_IN_USE, 16'($urandom_range(1, 3)));
         end else if (phases == 1) begin
            write_csr(CSR_COLS_IN_USE, 16'($urandom_range(1, 4)));
            write_csr(CSR_B_ROWS_IN_USE, 16'($urandom_range(1, 16)));
            write_csr(CSR_A_ROWS_IN_USE, 16'hFFFF);
         end else begin
            case ($urandom_range(0, 9))
               0: c = 0;
               1: c = 1;
               default: c = $urandom_range(2, 8);
            endcase
            write_csr(CSR_COLS_IN_USE, 16'({$urandom_range(0, 127), 9'(c)}));
            case ($urandom_range(0, 5))
               0: c = 0;
               1: c = 31;
               2: c = 16;
               default: c = $urandom_range(1, 16);
            endcase
            write_csr(CSR_B_ROWS_IN_USE, 16'({$urandom_range(0, 2047), 5'(c)}));
            case ($urandom_range(0, 4))
               0: c = 0;
               1: c = 1;
               default: c = $urandom_range(1, 4);
            endcase
            write_csr(CSR_A_ROWS_IN_USE, 16'(c));
         end
         phases++;
         for (j = 0; j < used_b_rows(); j++)
            for (c = 0; c < used_cols(); c++)
               send_item(ACTION_LOAD_B, j[B_ROW_W-1:0], c[COL_IDX_W-1:0], pick_value());
         repeat ($urandom_range(0, 3))
            send_item(ACTION_LOAD_B, 4'($urandom), 8'($urandom), pick_value());
         n = $urandom_range(1, 3) * used_cols();
         for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               wait_quiet();
               write_random_reg();
            end else if (r < 7) begin
               send_item(ACTION_LOAD_B, 4'($urandom), 8'($urandom), pick_value());
            end else begin
               fill_missing();
               send_item(ACTION_STREAM_A, 4'($urandom), 8'($urandom), pick_value());
            end
         end
      end

      start <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_dots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Accepted %0d items over %0d register settings and checked %0d dot products.",
               items_accepted, phases + 3, dots_checked);
      $display("Covered capped and zero registers, mid-row register changes and loads.");
      if (errors == 0 && expected_dots.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/mtt_pkg.sv
rtl/mtt_bstore.sv
rtl/mtt_mac.sv
rtl/mtt_ctrl.sv
rtl/matrix_times_transpose_core.sv
tb/tb_top.sv
